/* hw/rtl/mean_square_displacement_tracker_macros.svh */
// Assertion macros for the displacement tracker checker.
// No dependencies.
`ifndef MEAN_SQUARE_DISPLACEMENT_TRACKER_MACROS_SVH
`define MEAN_SQUARE_DISPLACEMENT_TRACKER_MACROS_SVH
`define MSD_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("lbl");
`define MSD_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error("lbl");
`endif

/* hw/rtl/msd_pkg.sv */
// Types and constants for the displacement tracker.
// No dependencies.
package msd_pkg;
  localparam int unsigned CoordW = 24;
  localparam int unsigned IdxW   = 10;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_BASE   = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic {
    CFG_SKIP   = 1'b0,
    CFG_CENTER = 1'b1
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_CALC, ST_SUMS, ST_DIV, ST_VAR, ST_OUT
  } bst_e;

  // classified request, front to back
  typedef struct packed {
    op_e                      op;
    logic [IdxW-1:0]          idx;
    logic                     ok;
    logic                     hit;
    logic signed [CoordW-1:0] rx;
    logic signed [CoordW-1:0] ry;
    logic signed [CoordW-1:0] rz;
    logic [31:0]              count;
  } req_t;

  function automatic logic signed [CoordW-1:0] rel_pos(
    input logic signed [CoordW-1:0] p, input logic signed [CoordW-1:0] c,
    input logic use_c);
    logic signed [CoordW:0] r;
    r = {p[CoordW-1], p} - (use_c ? {c[CoordW-1], c} : '0);
    if (r[CoordW] != r[CoordW-1]) begin
      rel_pos = r[CoordW] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end else begin
      rel_pos = r[CoordW-1:0];
    end
  endfunction
endpackage

/* hw/rtl/msd_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module msd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

/* hw/rtl/msd_front.sv */
// Front end: accepts items, owns frame phase and count, classifies requests.
// Depends on msd_pkg.
module msd_front #(
  parameter int unsigned Atoms = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       opcode_i,
  input  logic [msd_pkg::IdxW-1:0]         atom_index_i,
  input  logic signed [msd_pkg::CoordW-1:0] pos_x_i,
  input  logic signed [msd_pkg::CoordW-1:0] pos_y_i,
  input  logic signed [msd_pkg::CoordW-1:0] pos_z_i,
  input  logic signed [msd_pkg::CoordW-1:0] center_x_i,
  input  logic signed [msd_pkg::CoordW-1:0] center_y_i,
  input  logic signed [msd_pkg::CoordW-1:0] center_z_i,
  input  logic                             last_atom_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [0:0]                       cfg_index_i,
  input  logic [15:0]                      cfg_data_i,
  output logic                             req_valid_o,
  input  logic                             req_ready_i,
  output msd_pkg::req_t                    req_o
);
  logic [15:0] skip_q, phase_q, phase_d;
  logic        center_q;
  logic [31:0] count_q, count_d;
  logic [15:0] skip_eff;
  logic [16:0] phase_inc;
  logic        hit, acc;
  msd_pkg::op_e op;

  assign cfg_ready_o = 1'b1;
  assign acc         = in_valid_i && in_ready_o;
  assign op          = msd_pkg::op_e'(opcode_i);
  assign skip_eff    = (skip_q == '0) ? 16'd1 : skip_q;
  assign phase_inc   = {1'b0, phase_q} + 17'd1;
  assign hit         = phase_inc >= {1'b0, skip_eff};

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    if (acc && last_atom_i) begin
      if (op == msd_pkg::OP_BASE) begin
        phase_d = '0;
        count_d = '0;
      end else if (op == msd_pkg::OP_SAMPLE) begin
        if (hit) begin
          phase_d = '0;
          if (count_q != '1) count_d = count_q + 32'd1;
        end else begin
          phase_d = phase_inc[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q   <= 16'd1;
      center_q <= 1'b1;
      phase_q  <= '0;
      count_q  <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      if (cfg_valid_i) begin
        unique case (msd_pkg::cfg_e'(cfg_index_i))
          msd_pkg::CFG_SKIP:   skip_q   <= cfg_data_i;
          msd_pkg::CFG_CENTER: center_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // two-entry queue to the back end
  msd_pkg::req_t fifo_q [2];
  logic [1:0]    cnt_q;
  logic          rd_q, wr_q;
  msd_pkg::req_t nreq;
  logic          pop;

  assign in_ready_o = cnt_q != 2'd2;

  always_comb begin
    nreq.op    = op;
    nreq.idx   = atom_index_i;
    nreq.ok    = 32'(atom_index_i) < Atoms;
    nreq.hit   = hit;
    nreq.rx    = msd_pkg::rel_pos(pos_x_i, center_x_i, center_q);
    nreq.ry    = msd_pkg::rel_pos(pos_y_i, center_y_i, center_q);
    nreq.rz    = msd_pkg::rel_pos(pos_z_i, center_z_i, center_q);
    nreq.count = count_q;
  end

  assign pop         = req_valid_o && req_ready_i;
  assign req_valid_o = cnt_q != 2'd0;
  assign req_o       = fifo_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (acc) fifo_q[wr_q] <= nreq;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      if (acc) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, acc} - {1'b0, pop};
    end
  end
endmodule

/* hw/rtl/msd_back.sv */
// Back end: per-particle memory update, division and result register.
// Depends on msd_pkg and msd_ram.
module msd_back #(
  parameter int unsigned Atoms = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  msd_pkg::req_t         req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [msd_pkg::IdxW-1:0] result_index_o,
  output logic                  sampled_o,
  output logic [31:0]           mean_disp_o,
  output logic signed [63:0]    var_disp_o,
  output logic [31:0]           sample_total_o,
  output logic                  no_samples_o
);
  localparam int unsigned AW = (Atoms > 1) ? $clog2(Atoms) : 1;
  localparam int unsigned BW = 3 * msd_pkg::CoordW;

  msd_pkg::bst_e st_q, st_d;
  msd_pkg::req_t r_q;
  logic [msd_pkg::IdxW-1:0] aidx;
  logic [AW-1:0] addr;
  logic          we_b, we_s;
  logic [BW-1:0] base_rd, base_wd;
  logic [63:0]   sum_rd, sq_rd, sum_wd, sq_wd;
  logic [63:0]   dx2_q, dy2_q, dz2_q, d_q, dd_q;
  logic [63:0]   s_q, q_q;
  logic [63:0]   rem_s_q, rem_q_q, quo_s_q, quo_q_q;
  logic [6:0]    bit_q;
  logic [31:0]   mean_q;
  logic [63:0]   msq_q;
  logic          take;

  // read address follows the incoming request while idle
  assign aidx = (st_q == msd_pkg::ST_IDLE) ? req_i.idx : r_q.idx;

  if (AW == msd_pkg::IdxW) begin : g_eq
    assign addr = aidx;
  end else if (AW < msd_pkg::IdxW) begin : g_lt
    assign addr = aidx[AW-1:0];
  end else begin : g_gt
    assign addr = {{(AW-msd_pkg::IdxW){1'b0}}, aidx};
  end

  msd_ram #(.Width(BW), .Depth(Atoms)) u_base (
    .clk_i, .we_i(we_b), .addr_i(addr), .wdata_i(base_wd), .rdata_o(base_rd));
  msd_ram #(.Width(64), .Depth(Atoms)) u_sum (
    .clk_i, .we_i(we_s), .addr_i(addr), .wdata_i(sum_wd), .rdata_o(sum_rd));
  msd_ram #(.Width(64), .Depth(Atoms)) u_sq (
    .clk_i, .we_i(we_s), .addr_i(addr), .wdata_i(sq_wd), .rdata_o(sq_rd));

  assign base_wd = {r_q.rx, r_q.ry, r_q.rz};
  assign take    = req_valid_i && req_ready_o;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      msd_pkg::ST_IDLE: if (take) begin
        unique case (req_i.op)
          msd_pkg::OP_SAMPLE: st_d = req_i.hit ? msd_pkg::ST_READ : msd_pkg::ST_OUT;
          msd_pkg::OP_QUERY:  st_d = (req_i.count == '0) ? msd_pkg::ST_OUT
                                                         : msd_pkg::ST_READ;
          default:            st_d = msd_pkg::ST_OUT;
        endcase
      end
      msd_pkg::ST_READ: st_d = (r_q.op == msd_pkg::OP_QUERY) ? msd_pkg::ST_DIV
                                                             : msd_pkg::ST_CALC;
      msd_pkg::ST_CALC: st_d = msd_pkg::ST_SUMS;
      msd_pkg::ST_SUMS: st_d = msd_pkg::ST_OUT;
      msd_pkg::ST_DIV:  if (bit_q == 7'd0) st_d = msd_pkg::ST_VAR;
      msd_pkg::ST_VAR:  st_d = msd_pkg::ST_OUT;
      msd_pkg::ST_OUT:  if (!out_valid_o || out_ready_i) st_d = msd_pkg::ST_IDLE;
      default:          st_d = msd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o = st_q == msd_pkg::ST_IDLE;
    we_b = 1'b0;
    we_s = 1'b0;
    sum_wd = '0;
    sq_wd  = '0;
    if (st_q == msd_pkg::ST_OUT && r_q.op == msd_pkg::OP_BASE && r_q.ok) begin
      we_b = 1'b1;
      we_s = 1'b1;
    end
    if (st_q == msd_pkg::ST_SUMS && r_q.ok) begin
      we_b = 1'b1;
      we_s = 1'b1;
      sum_wd = (s_q + d_q < s_q) ? '1 : s_q + d_q;
      sq_wd  = (q_q + dd_q < q_q) ? '1 : q_q + dd_q;
    end
  end

  logic signed [msd_pkg::CoordW:0] ex, ey, ez;
  logic signed [msd_pkg::CoordW-1:0] bx, by, bz;
  logic [65:0] dsum;
  logic [47:0] dsh;
  logic [31:0] dsat;
  assign bx = r_q.ok ? base_rd[BW-1 -: msd_pkg::CoordW] : '0;
  assign by = r_q.ok ? base_rd[2*msd_pkg::CoordW-1 -: msd_pkg::CoordW] : '0;
  assign bz = r_q.ok ? base_rd[msd_pkg::CoordW-1:0] : '0;
  assign ex = {r_q.rx[msd_pkg::CoordW-1], r_q.rx} - {bx[msd_pkg::CoordW-1], bx};
  assign ey = {r_q.ry[msd_pkg::CoordW-1], r_q.ry} - {by[msd_pkg::CoordW-1], by};
  assign ez = {r_q.rz[msd_pkg::CoordW-1], r_q.rz} - {bz[msd_pkg::CoordW-1], bz};
  assign dsum = {2'b0, dx2_q} + {2'b0, dy2_q} + {2'b0, dz2_q};
  assign dsh  = dsum[63:16];
  assign dsat = (dsh[47:32] != '0) ? '1 : dsh[31:0];

  logic [64:0] trs, trq;
  assign trs = {rem_s_q[62:0], quo_s_q[63]} - {1'b0, r_q.count};
  assign trq = {rem_q_q[62:0], quo_q_q[63]} - {1'b0, r_q.count};

  logic [63:0] qm;
  logic [64:0] vdiff;
  assign qm = quo_q_q;

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      msd_pkg::ST_IDLE: if (take) r_q <= req_i;
      msd_pkg::ST_READ: begin
        dx2_q <= 64'(ex * ex);
        dy2_q <= 64'(ey * ey);
        dz2_q <= 64'(ez * ez);
        s_q   <= r_q.ok ? sum_rd : '0;
        q_q   <= r_q.ok ? sq_rd : '0;
        rem_s_q <= '0;
        rem_q_q <= '0;
        quo_s_q <= r_q.ok ? sum_rd : '0;
        quo_q_q <= r_q.ok ? sq_rd : '0;
        bit_q   <= 7'd63;
      end
      msd_pkg::ST_CALC: begin
        d_q  <= {32'd0, dsat};
        dd_q <= 64'(dsat) * 64'(dsat);
      end
      msd_pkg::ST_DIV: begin
        rem_s_q <= trs[64] ? {rem_s_q[62:0], quo_s_q[63]} : trs[63:0];
        quo_s_q <= {quo_s_q[62:0], ~trs[64]};
        rem_q_q <= trq[64] ? {rem_q_q[62:0], quo_q_q[63]} : trq[63:0];
        quo_q_q <= {quo_q_q[62:0], ~trq[64]};
        bit_q   <= bit_q - 7'd1;
        if (bit_q == 7'd0) begin
          mean_q <= (quo_s_q[62:31] != '0 || (quo_s_q[63:31] != '0))
                    ? ((({quo_s_q[62:0], ~trs[64]}) > 64'hFFFF_FFFF) ? '1
                       : quo_s_q[62:0] >> 0 == 0 ? 32'({quo_s_q[62:0], ~trs[64]})
                       : 32'({quo_s_q[62:0], ~trs[64]}))
                    : 32'({quo_s_q[62:0], ~trs[64]});
        end
      end
      msd_pkg::ST_VAR: msq_q <= 64'(mean_q) * 64'(mean_q);
      default: ;
    endcase
  end

  assign vdiff = {1'b0, qm} - {1'b0, msq_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= msd_pkg::ST_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == msd_pkg::ST_OUT && (!out_valid_o || out_ready_i)) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == msd_pkg::ST_OUT && (!out_valid_o || out_ready_i)) begin
      result_index_o <= r_q.idx;
      sampled_o      <= r_q.op == msd_pkg::OP_SAMPLE && r_q.hit;
      if (r_q.op == msd_pkg::OP_QUERY) begin
        sample_total_o <= r_q.count;
        no_samples_o   <= r_q.count == '0;
        if (r_q.count == '0) begin
          mean_disp_o <= '0;
          var_disp_o  <= '0;
        end else begin
          mean_disp_o <= mean_q;
          if (!vdiff[64]) begin
            var_disp_o <= vdiff[63] ? {1'b0, {63{1'b1}}} : vdiff[63:0];
          end else begin
            var_disp_o <= (!vdiff[63]) ? {1'b1, 63'd0} : vdiff[63:0];
          end
        end
      end else begin
        mean_disp_o    <= '0;
        var_disp_o     <= '0;
        sample_total_o <= '0;
        no_samples_o   <= 1'b0;
      end
    end
  end
endmodule

/* hw/rtl/mean_square_displacement_tracker.sv */
// A sampled sample passes back-end states read, calc, sums and out; a query
// with samples passes read, div (64-step dividers for sum and square), var and
// out; all others go straight to out. The back end holds one request at a
// time; a two-entry queue in front accepts input while it has room. Result is
// registered. Async active-low reset clears control, config to skip 1 / center
// on. Particle memories are not cleared; a particle is valid once baselined.
module mean_square_displacement_tracker #(
  parameter int unsigned ATOMS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic [9:0]         atom_index_i,
  input  logic signed [23:0] pos_x_i,
  input  logic signed [23:0] pos_y_i,
  input  logic signed [23:0] pos_z_i,
  input  logic signed [23:0] center_x_i,
  input  logic signed [23:0] center_y_i,
  input  logic signed [23:0] center_z_i,
  input  logic               last_atom_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [0:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [9:0]         result_index_o,
  output logic               sampled_o,
  output logic [31:0]        mean_disp_o,
  output logic signed [63:0] var_disp_o,
  output logic [31:0]        sample_total_o,
  output logic               no_samples_o
);
  logic          req_valid, req_ready;
  msd_pkg::req_t req;

  msd_front #(.Atoms(ATOMS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .opcode_i, .atom_index_i,
    .pos_x_i, .pos_y_i, .pos_z_i, .center_x_i, .center_y_i, .center_z_i,
    .last_atom_i, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .req_valid_o(req_valid), .req_ready_i(req_ready), .req_o(req));

  msd_back #(.Atoms(ATOMS)) u_back (
    .clk_i, .rst_ni, .req_valid_i(req_valid), .req_ready_o(req_ready),
    .req_i(req), .out_valid_o, .out_ready_i, .result_index_o, .sampled_o,
    .mean_disp_o, .var_disp_o, .sample_total_o, .no_samples_o);
endmodule

/* hw/rtl/msd_checker.sv */
// Port-level checks for the displacement tracker, bound to the top level.
// Depends on mean_square_displacement_tracker_macros.svh.
`include "mean_square_displacement_tracker_macros.svh"
module msd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        sampled_o,
  input logic        no_samples_o,
  input logic [31:0] mean_disp_o,
  input logic [31:0] sample_total_o
);
  `MSD_ASSERT_NXT(out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `MSD_ASSERT_IMP(none_zero, clk_i, rst_ni, out_valid_o && no_samples_o,
                  mean_disp_o == '0 && sample_total_o == '0)
  `MSD_ASSERT_IMP(excl, clk_i, rst_ni, out_valid_o && sampled_o, !no_samples_o)
endmodule

bind mean_square_displacement_tracker msd_checker u_msd_checker (.*);

/* tb/tb_top.sv */
// Self-checking bench for mean_square_displacement_tracker: directed table then random
// baseline/sample/query frames, checked against an in-bench predictor. Depends on msd_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import msd_pkg::*;

  typedef struct {
    logic [9:0]  idx;
    logic        smp;
    logic [31:0] mean;
    logic [63:0] vr;
    logic [31:0] total;
    logic        none;
  } msd_res_t;

  typedef struct {
    op_e        op;
    bit [9:0]   idx;
    bit [23:0]  px, py, pz, cx, cy, cz;
    bit         last;
    bit         typed;
    bit         smp, none;
  } row_t;

  localparam bit [23:0] PMAX = 24'h7FFFFF;
  localparam bit [23:0] PMIN = 24'h800000;
  localparam int WDOG = 3000;

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, cfg_valid_i = 0, out_ready_i = 0, last_atom_i = 0;
  logic [1:0] opcode_i = '0;
  logic [9:0] atom_index_i = '0;
  logic signed [23:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic signed [23:0] center_x_i = '0, center_y_i = '0, center_z_i = '0;
  logic [0:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic in_ready_o, cfg_ready_o, out_valid_o, sampled_o, no_samples_o;
  logic [9:0] result_index_o;
  logic [31:0] mean_disp_o, sample_total_o;
  logic signed [63:0] var_disp_o;

  mean_square_displacement_tracker dut (.*);

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  // predictor state
  bit [15:0] skip_r;
  bit        center_on;
  bit signed [23:0] bx[1024], by[1024], bz[1024];
  bit [63:0] dsum[1024], dsq[1024];
  bit [31:0] frames;
  bit [15:0] phase;
  bit        written[1024];

  msd_res_t expq[$];
  int errors = 0, n_items = 0, n_results = 0, n_hits = 0, n_queries = 0;
  bit quiet = 0;
  int idle_odds = 6;
  int wd = 0;

  function automatic bit signed [23:0] rel(bit signed [23:0] p, bit signed [23:0] c);
    int r;
    r = int'(p) - (center_on ? int'(c) : 0);
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    return r[23:0];
  endfunction

  function automatic bit [63:0] sq(bit signed [23:0] a, bit signed [23:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return d * d;
  endfunction

  function automatic bit [63:0] sadd(bit [63:0] a, bit [63:0] b);
    bit [64:0] s;
    s = a + b;
    return s[64] ? 64'hFFFFFFFFFFFFFFFF : s[63:0];
  endfunction

  function automatic msd_res_t predict_msd(op_e op, bit [9:0] i, bit [23:0] px, py, pz,
                                           cx, cy, cz, bit last);
    msd_res_t r;
    bit hit;
    bit signed [23:0] rx, ry, rz;
    bit [63:0] d, m, qm, msq;
    r = '{i, 0, 0, 0, 0, 0};
    case (op)
      OP_BASE: begin
        bx[i] = rel(px, cx); by[i] = rel(py, cy); bz[i] = rel(pz, cz);
        dsum[i] = 0; dsq[i] = 0; written[i] = 1;
        if (last) begin
          phase = 0; frames = 0;
        end
      end
      OP_SAMPLE: begin
        hit = 32'(phase) + 1 >= (skip_r == 0 ? 1 : 32'(skip_r));
        if (hit) begin
          rx = rel(px, cx); ry = rel(py, cy); rz = rel(pz, cz);
          d = (sq(rx, bx[i]) + sq(ry, by[i]) + sq(rz, bz[i])) >> 16;
          if (d > 64'hFFFFFFFF) d = 64'hFFFFFFFF;
          dsum[i] = sadd(dsum[i], d);
          dsq[i] = sadd(dsq[i], d * d);
          bx[i] = rx; by[i] = ry; bz[i] = rz;
          r.smp = 1;
        end
        if (last) begin
          if (hit) begin
            phase = 0;
            if (frames != 32'hFFFFFFFF) frames++;
          end else phase++;
        end
      end
      OP_QUERY: begin
        r.total = frames;
        if (frames == 0) r.none = 1;
        else begin
          m = dsum[i] / frames;
          if (m > 64'hFFFFFFFF) m = 64'hFFFFFFFF;
          qm = dsq[i] / frames;
          msq = m * m;
          if (qm >= msq) r.vr = (qm - msq) > 64'h7FFFFFFFFFFFFFFF ?
                                64'h7FFFFFFFFFFFFFFF : qm - msq;
          else r.vr = (msq - qm) >= 64'h8000000000000000 ?
                      64'h8000000000000000 : 64'd0 - (msq - qm);
          r.mean = m[31:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send(op_e op, bit [9:0] i, bit [23:0] px, py, pz, cx, cy, cz,
                      bit last, bit typed = 0, msd_res_t typ = '{0, 0, 0, 0, 0, 0});
    msd_res_t r;
    if (!quiet && $urandom_range(0, idle_odds) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1;
    opcode_i <= op; atom_index_i <= i; last_atom_i <= last;
    pos_x_i <= px; pos_y_i <= py; pos_z_i <= pz;
    center_x_i <= cx; center_y_i <= cy; center_z_i <= cz;
    do @(posedge clk_i); while (!in_ready_o);
    r = predict_msd(op, i, px, py, pz, cx, cy, cz, last);
    if (r.smp) n_hits++;
    if (op == OP_QUERY) n_queries++;
    if (typed) r = typ;
    expq = {expq, r};
    n_items++;
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (expq.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_e reg_sel, bit [15:0] val);
    cfg_valid_i <= 1; cfg_index_i <= reg_sel; cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (reg_sel == CFG_SKIP) skip_r = val;
    else center_on = val[0];
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  function automatic bit [23:0] rnd_coord();
    case ($urandom_range(0, 9))
      0: return PMAX;
      1: return PMIN;
      2, 3, 4, 5: return 24'($signed($urandom_range(0, 4095)) - 2048);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic rnd_send(op_e op, bit [9:0] i, bit last);
    send(op, i, rnd_coord(), rnd_coord(), rnd_coord(),
         rnd_coord(), rnd_coord(), rnd_coord(), last);
  endtask

  function automatic bit [9:0] any_written();
    bit [9:0] i;
    do i = 10'($urandom); while (!written[i]);
    return i;
  endfunction

  // random frames: mostly baseline and sample frames over a small particle set
  task automatic rnd_phase(int n);
    bit [9:0] set[$];
    int k, stop;
    stop = n_items + n;
    while (n_items < stop) begin
      k = $urandom_range(0, 19);
      if (set.size() == 0 || k == 0) begin
        set.delete();
        repeat ($urandom_range(1, 6))
          set = {set, ($urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 10'h3FF : 10'h0)
                                                : 10'($urandom))};
        foreach (set[j]) rnd_send(OP_BASE, set[j], j == set.size() - 1);
      end else if (k < 14) begin
        foreach (set[j]) rnd_send(OP_SAMPLE, set[j], j == set.size() - 1);
      end else if (k < 18) begin
        rnd_send(OP_QUERY, any_written(), $urandom_range(0, 1));
      end else if (k == 18) begin
        rnd_send(OP_NONE, 10'($urandom), $urandom_range(0, 1));
      end else begin
        rnd_send(OP_SAMPLE, any_written(), $urandom_range(0, 1));
      end
    end
  endtask

  row_t dir_tab[] = '{
    '{OP_BASE,   10'd0,   PMAX, PMIN, 24'd0, PMIN, PMAX, 24'd0, 0, 1, 0, 0},
    '{OP_BASE,   10'h3FF, PMIN, PMAX, PMAX, PMAX, PMIN, PMIN, 1, 1, 0, 0},
    '{OP_QUERY,  10'd0,   0, 0, 0, 0, 0, 0, 0, 1, 0, 1},
    '{OP_SAMPLE, 10'd0,   PMIN, PMAX, PMIN, PMAX, PMIN, PMAX, 0, 1, 1, 0},
    '{OP_SAMPLE, 10'h3FF, PMAX, PMIN, PMIN, PMIN, PMAX, PMAX, 1, 1, 1, 0},
    '{OP_QUERY,  10'd0,   0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{OP_QUERY,  10'h3FF, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0},
    '{OP_NONE,   10'd5,   PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, 1, 1, 0, 0},
    '{OP_BASE,   10'd5,   24'h10000, 0, 0, 0, 0, 0, 1, 1, 0, 0},
    '{OP_SAMPLE, 10'd5,   24'h30000, 24'h20000, 0, 0, 0, 0, 0, 1, 1, 0},
    '{OP_SAMPLE, 10'd0,   24'h1234, 24'hFFF000, 24'h42, 24'h5, 24'h7, 24'h9, 1, 0, 0, 0},
    '{OP_SAMPLE, 10'd5,   24'h50000, 24'h20000, 0, 0, 0, 0, 1, 0, 0, 0},
    '{OP_QUERY,  10'd5,   0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{OP_QUERY,  10'd0,   0, 0, 0, 0, 0, 0, 1, 0, 0, 0}
  };

  // results
  always @(posedge clk_i) begin
    msd_res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (expq.size() == 0) begin
        $display("%0t: unexpected result idx %0d", $time, result_index_o);
        errors++;
      end else begin
        e = expq[0];
        expq.delete(0);
        if (result_index_o !== e.idx || sampled_o !== e.smp || mean_disp_o !== e.mean ||
            var_disp_o !== e.vr || sample_total_o !== e.total || no_samples_o !== e.none) begin
          $display("%0t: mismatch exp idx %0d smp %0b mean %h var %h total %0d none %0b",
                   $time, e.idx, e.smp, e.mean, e.vr, e.total, e.none);
          $display("%0t:          got idx %0d smp %0b mean %h var %h total %0d none %0b",
                   $time, result_index_o, sampled_o, mean_disp_o, var_disp_o,
                   sample_total_o, no_samples_o);
          errors++;
        end
      end
    end
  end

  initial begin
    forever begin
      if (quiet) begin
        out_ready_i <= 1;
        @(posedge clk_i);
      end else begin
        out_ready_i <= 1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
        out_ready_i <= 0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) wd <= 0;
    else wd <= wd + 1;
    if (wd >= WDOG) begin
      $display("%0t: timeout, %0d requests pending", $time, expq.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    msd_res_t typ;
    skip_r = 1; center_on = 1; frames = 0; phase = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    write_cfg(CFG_SKIP, 16'd1);
    write_cfg(CFG_CENTER, 1'b1);
    foreach (dir_tab[r]) begin
      typ = '{dir_tab[r].idx, dir_tab[r].smp, 0, 0, 0, dir_tab[r].none};
      send(dir_tab[r].op, dir_tab[r].idx, dir_tab[r].px, dir_tab[r].py, dir_tab[r].pz,
           dir_tab[r].cx, dir_tab[r].cy, dir_tab[r].cz, dir_tab[r].last,
           dir_tab[r].typed, typ);
    end
    drain();
    rnd_phase(180);
    drain(); write_cfg(CFG_SKIP, 16'd3); write_cfg(CFG_CENTER, 1'b0); idle_odds = 2;
    rnd_phase(160);
    drain(); write_cfg(CFG_SKIP, 16'd0); idle_odds = 40;
    rnd_phase(140);
    drain(); write_cfg(CFG_SKIP, 16'hFFFF); write_cfg(CFG_CENTER, 1'b1); idle_odds = 6;
    rnd_phase(60);
    drain(); write_cfg(CFG_SKIP, 16'd2);
    rnd_phase(160);
    drain(); write_cfg(CFG_SKIP, 16'd1); quiet = 1;
    rnd_phase(200);
    in_valid_i <= 0;
    while (expq.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (expq.size() != 0) errors++;
    $display("Sent %0d requests (%0d queries, %0d sampled), checked %0d results.",
             n_items, n_queries, n_hits, n_results);
    $display("Skip settings 0/1/2/3/65535, centering on and off, %0d errors.", errors);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
